// File: rtl/cpos_pkg.sv
package cpos_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_INTERIOR = 2'd0,
    ST_START    = 2'd1,
    ST_END      = 2'd2,
    ST_DEGEN    = 2'd3
  } cpos_status_t;

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 4;

endpackage

// File: rtl/cpos_if.sv
// query channel: two end points and a query point
interface cpos_in_if #(
  parameter int unsigned W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a_x, a_y, a_z;
  logic signed [W-1:0] b_x, b_y, b_z;
  logic signed [W-1:0] p_x, p_y, p_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z,
                  input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z,
                  output ready);
endinterface

// result channel: closest point and status
interface cpos_out_if #(
  parameter int unsigned W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] q_x, q_y, q_z;
  logic [1:0]          status;

  modport source (output valid, q_x, q_y, q_z, status, input ready);
  modport sink   (input valid, q_x, q_y, q_z, status, output ready);
endinterface

// File: rtl/closest_point_on_segment.sv
// Closest point on a 3D segment, signed fixed point.
// in_chan carries end points A, B and query point P; out_chan returns the
// closest point Q on segment AB and a status (interior, clamped to start,
// clamped to end, degenerate segment). For 2D use, drive all z to zero.
// Both channels use valid/ready; a transaction moves when both are high.
// Throughput: one transaction per cycle while out_chan does not stall. A
// transaction passes three front stages (differences, products, dot
// products and class), the queue, one load stage, FRAC_BITS divider
// stages (one quotient bit each), the offset multiply and the output
// register.
// The front and back are split by a four-entry queue; when out_chan stalls,
// the back pipeline holds, the queue fills, and then in_chan.ready drops.
// Reset clears all valid bits and the queue; no item is in flight after it.
module closest_point_on_segment import cpos_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  cpos_in_if.sink    in_chan,
  cpos_out_if.source out_chan
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned SW = 2 * DW + 2;
  localparam int unsigned EW = 6 * COORD_WIDTH + 3 * DW + 2 * SW + 2;

  logic          push, full, pop, not_empty;
  logic [EW-1:0] push_data, pop_data;

  cpos_front #(.W(COORD_WIDTH), .EW(EW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  cpos_fifo #(.EW(EW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  cpos_back #(.W(COORD_WIDTH), .F(FRAC_BITS), .EW(EW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

// File: rtl/cpos_front.sv
module cpos_front import cpos_pkg::*; #(
  parameter int unsigned W  = 32,
  parameter int unsigned EW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  cpos_in_if.sink       in_chan,
  output logic          push,
  output logic [EW-1:0] push_data,
  input  logic          full
);

  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 2;

  logic en;
  logic v1_r, v2_r, v3_r;

  // stage 1: differences
  logic signed [W-1:0]  a_x_r, a_y_r, a_z_r, b_x_r, b_y_r, b_z_r;
  logic signed [DW-1:0] ab_x_r, ab_y_r, ab_z_r, pa_x_r, pa_y_r, pa_z_r;
  // stage 2: products
  logic signed [W-1:0]  a2_x_r, a2_y_r, a2_z_r, b2_x_r, b2_y_r, b2_z_r;
  logic signed [DW-1:0] ab2_x_r, ab2_y_r, ab2_z_r;
  logic signed [PW-1:0] pn_x_r, pn_y_r, pn_z_r, pd_x_r, pd_y_r, pd_z_r;
  // stage 3: sums and class
  logic signed [SW-1:0] num_nxt, den_nxt;
  cpos_status_t         st_nxt;
  logic [EW-1:0]        ent_r;

  // whole front moves unless the last stage is stuck on a full queue
  assign en            = !v3_r || !full;
  assign in_chan.ready = en;
  assign push          = v3_r;
  assign push_data     = ent_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_chan.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r  <= in_chan.a_x;
      a_y_r  <= in_chan.a_y;
      a_z_r  <= in_chan.a_z;
      b_x_r  <= in_chan.b_x;
      b_y_r  <= in_chan.b_y;
      b_z_r  <= in_chan.b_z;
      ab_x_r <= {in_chan.b_x[W-1], in_chan.b_x} - {in_chan.a_x[W-1], in_chan.a_x};
      ab_y_r <= {in_chan.b_y[W-1], in_chan.b_y} - {in_chan.a_y[W-1], in_chan.a_y};
      ab_z_r <= {in_chan.b_z[W-1], in_chan.b_z} - {in_chan.a_z[W-1], in_chan.a_z};
      pa_x_r <= {in_chan.p_x[W-1], in_chan.p_x} - {in_chan.a_x[W-1], in_chan.a_x};
      pa_y_r <= {in_chan.p_y[W-1], in_chan.p_y} - {in_chan.a_y[W-1], in_chan.a_y};
      pa_z_r <= {in_chan.p_z[W-1], in_chan.p_z} - {in_chan.a_z[W-1], in_chan.a_z};
    end
  end

  // stage 2: one multiplier per term
  always_ff @(posedge clk) begin
    if (en) begin
      a2_x_r  <= a_x_r;
      a2_y_r  <= a_y_r;
      a2_z_r  <= a_z_r;
      b2_x_r  <= b_x_r;
      b2_y_r  <= b_y_r;
      b2_z_r  <= b_z_r;
      ab2_x_r <= ab_x_r;
      ab2_y_r <= ab_y_r;
      ab2_z_r <= ab_z_r;
      pn_x_r  <= pa_x_r * ab_x_r;
      pn_y_r  <= pa_y_r * ab_y_r;
      pn_z_r  <= pa_z_r * ab_z_r;
      pd_x_r  <= ab_x_r * ab_x_r;
      pd_y_r  <= ab_y_r * ab_y_r;
      pd_z_r  <= ab_z_r * ab_z_r;
    end
  end

  // stage 3: dot products and classification
  always_comb begin
    num_nxt = SW'(pn_x_r) + SW'(pn_y_r) + SW'(pn_z_r);
    den_nxt = SW'(pd_x_r) + SW'(pd_y_r) + SW'(pd_z_r);
    if (den_nxt == '0) begin
      st_nxt = ST_DEGEN;
    end else if (num_nxt[SW-1] || num_nxt == '0) begin
      st_nxt = ST_START;
    end else if (num_nxt >= den_nxt) begin
      st_nxt = ST_END;
    end else begin
      st_nxt = ST_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= {a2_x_r, a2_y_r, a2_z_r, b2_x_r, b2_y_r, b2_z_r,
                ab2_x_r, ab2_y_r, ab2_z_r, num_nxt, den_nxt, st_nxt};
    end
  end

endmodule

// File: rtl/cpos_fifo.sv
module cpos_fifo import cpos_pkg::*; #(
  parameter int unsigned EW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [EW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [EW-1:0] pop_data
);

  localparam int unsigned AW = $clog2(QDEPTH);

  logic [EW-1:0] mem_r [QDEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full      = (cnt_r == (AW + 1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW + 1)'(QDEPTH))
    else $error("queue count overflow");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 || cnt_r == (AW + 1)'(QDEPTH) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers out of step");
`endif

endmodule

// File: rtl/cpos_back.sv
module cpos_back import cpos_pkg::*; #(
  parameter int unsigned W  = 32,
  parameter int unsigned F  = 16,
  parameter int unsigned EW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          not_empty,
  input  logic [EW-1:0] pop_data,
  output logic          pop,
  cpos_out_if.source    out_chan
);

  localparam int unsigned DW = W + 1;
  localparam int unsigned SW = 2 * DW + 2;
  localparam int unsigned MW = DW + F + 1;
  localparam int unsigned XW = MW + 1;

  logic en;

  // divider pipeline, one quotient bit per stage
  logic                 sv_r  [F+1];
  logic [SW:0]          rem_r [F+1];
  logic [SW-1:0]        den_r [F+1];
  logic [F-1:0]         t_r   [F+1];
  logic [3*W-1:0]       a_r   [F+1];
  logic [3*W-1:0]       b_r   [F+1];
  logic [3*DW-1:0]      ab_r  [F+1];
  logic [1:0]           st_r  [F+1];

  // multiply stage
  logic                 mv_r;
  logic signed [MW-1:0] off_x_r, off_y_r, off_z_r;
  logic [3*W-1:0]       ma_r, mb_r;
  logic [1:0]           mst_r;

  // output register
  logic                 out_valid_r;
  logic signed [W-1:0]  q_x_r, q_y_r, q_z_r, q_x_nxt, q_y_nxt, q_z_nxt;
  logic [1:0]           st_out_r;

  logic signed [SW-1:0] num_in;

  assign en             = !out_valid_r || out_chan.ready;
  assign pop            = en;
  assign out_chan.valid = out_valid_r;
  assign out_chan.q_x   = q_x_r;
  assign out_chan.q_y   = q_y_r;
  assign out_chan.q_z   = q_z_r;
  assign out_chan.status = st_out_r;
  assign num_in         = pop_data[2 + 2*SW - 1 -: SW];

  // stage 0 loads from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]   <= pop_data[EW-1 -: 3*W];
      b_r[0]   <= pop_data[EW-1-3*W -: 3*W];
      ab_r[0]  <= pop_data[EW-1-6*W -: 3*DW];
      rem_r[0] <= {1'b0, num_in};
      den_r[0] <= pop_data[2 +: SW];
      st_r[0]  <= pop_data[1:0];
      t_r[0]   <= '0;
    end
  end

  // restoring division steps
  for (genvar k = 1; k <= F; k++) begin : g_div
    logic [SW:0] r2;
    logic        ge;
    assign r2 = {rem_r[k-1][SW-1:0], 1'b0};
    assign ge = (r2 >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k] <= 1'b0;
      end else if (en) begin
        sv_r[k] <= sv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (r2 - {1'b0, den_r[k-1]}) : r2;
        t_r[k]   <= {t_r[k-1][F-2:0], ge};
        den_r[k] <= den_r[k-1];
        a_r[k]   <= a_r[k-1];
        b_r[k]   <= b_r[k-1];
        ab_r[k]  <= ab_r[k-1];
        st_r[k]  <= st_r[k-1];
      end
    end
  end

  // offsets AB * t
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= sv_r[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_x_r <= $signed(ab_r[F][3*DW-1 -: DW]) * $signed({1'b0, t_r[F]});
      off_y_r <= $signed(ab_r[F][2*DW-1 -: DW]) * $signed({1'b0, t_r[F]});
      off_z_r <= $signed(ab_r[F][DW-1 -: DW])   * $signed({1'b0, t_r[F]});
      ma_r    <= a_r[F];
      mb_r    <= b_r[F];
      mst_r   <= st_r[F];
    end
  end

  // A + offset, saturated
  function automatic logic signed [W-1:0] add_sat(logic signed [W-1:0] a,
                                                  logic signed [MW-1:0] off);
    logic signed [MW-1:0] sh;
    logic signed [XW-1:0] s;
    logic                 hi, lo;
    sh = off >>> F;
    s  = XW'(a) + XW'(sh);
    hi = !s[XW-1] && (s[XW-2:W-1] != '0);
    lo = s[XW-1] && (s[XW-2:W-1] != '1);
    if (hi) begin
      add_sat = {1'b0, {(W-1){1'b1}}};
    end else if (lo) begin
      add_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      add_sat = s[W-1:0];
    end
  endfunction

  // pick the result by class
  always_comb begin
    case (cpos_status_t'(mst_r))
      ST_INTERIOR: begin
        q_x_nxt = add_sat(ma_r[3*W-1 -: W], off_x_r);
        q_y_nxt = add_sat(ma_r[2*W-1 -: W], off_y_r);
        q_z_nxt = add_sat(ma_r[W-1 -: W],   off_z_r);
      end
      ST_END: begin
        q_x_nxt = mb_r[3*W-1 -: W];
        q_y_nxt = mb_r[2*W-1 -: W];
        q_z_nxt = mb_r[W-1 -: W];
      end
      default: begin
        q_x_nxt = ma_r[3*W-1 -: W];
        q_y_nxt = ma_r[2*W-1 -: W];
        q_z_nxt = ma_r[W-1 -: W];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_x_r    <= q_x_nxt;
      q_y_r    <= q_y_nxt;
      q_z_r    <= q_z_nxt;
      st_out_r <= mst_r;
    end
  end

`ifndef SYNTHESIS
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    en && mv_r |=> out_valid_r)
    else $error("transaction lost at output stage");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(mv_r) && $stable(sv_r[F]))
    else $error("pipeline moved while stalled");
  a_start_pt: assert property (@(posedge clk) disable iff (!rst_n)
    en && mv_r && (mst_r == ST_START || mst_r == ST_DEGEN)
      |=> q_x_r == $past(ma_r[3*W-1 -: W]))
    else $error("clamped result is not the start point");
`endif

endmodule

// File: tb/sv/tb_closest_point_on_segment.sv
module tb_closest_point_on_segment;
  import cpos_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned LATENCY = FB + 7;
  localparam int N_RANDOM = 1700;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z;
  } query_t;

  typedef struct packed {
    coord_t       q_x, q_y, q_z;
    cpos_status_t status;
  } point_t;

  logic clk;
  logic rst_n;

  cpos_in_if  #(.W(CW)) in_chan ();
  cpos_out_if #(.W(CW)) out_chan ();

  closest_point_on_segment #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  query_t pending_q[$];
  point_t closest_q[$];
  int     n_fail = 0;
  bit     calm = 0;        // no idling in the last part
  bit     hold_out = 0;    // long receiver hold-off request
  bit     pause_in = 0;    // sender drains before continuing

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Expected closest point for one query
  function automatic point_t closest_point(query_t q);
    coord_t a[3], b[3], p[3];
    logic signed [127:0] ab[3];
    logic signed [127:0] num, den, off;
    logic signed [127:0] t;
    logic signed [127:0] v;
    logic signed [127:0] maxv, minv;
    coord_t r[3];
    point_t res;
    a = '{q.a_x, q.a_y, q.a_z};
    b = '{q.b_x, q.b_y, q.b_z};
    p = '{q.p_x, q.p_y, q.p_z};
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = 128'(b[i]) - 128'(a[i]);
      num += (128'(p[i]) - 128'(a[i])) * ab[i];
      den += ab[i] * ab[i];
    end
    maxv = (128'sd1 <<< (CW - 1)) - 1;
    minv = -(128'sd1 <<< (CW - 1));
    if (den == 0) begin
      res.status = ST_DEGEN;
      r = a;
    end else if (num <= 0) begin
      res.status = ST_START;
      r = a;
    end else if (num >= den) begin
      res.status = ST_END;
      r = b;
    end else begin
      res.status = ST_INTERIOR;
      t = (num <<< FB) / den;
      for (int i = 0; i < 3; i++) begin
        off = (ab[i] * t) >>> FB;
        v = 128'(a[i]) + off;
        if (v > maxv) v = maxv;
        else if (v < minv) v = minv;
        r[i] = v[CW-1:0];
      end
    end
    res.q_x = r[0];
    res.q_y = r[1];
    res.q_z = r[2];
    return res;
  endfunction

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return coord_t'($signed($urandom_range(0, 200000)) - 100000);
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'($signed($urandom_range(0, 60)) - 30) <<< 16;
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    q.a_x = rnd_coord(); q.a_y = rnd_coord(); q.a_z = rnd_coord();
    q.p_x = rnd_coord(); q.p_y = rnd_coord(); q.p_z = rnd_coord();
    if ($urandom_range(0, 15) == 0) begin
      q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z;
    end else begin
      q.b_x = rnd_coord(); q.b_y = rnd_coord(); q.b_z = rnd_coord();
    end
    if ($urandom_range(0, 7) == 0) begin
      q.a_z = 0; q.b_z = 0; q.p_z = 0;
    end
    return q;
  endfunction

  // Stimulus
  initial begin
    localparam coord_t MX = 32'sh7fffffff;
    localparam coord_t MN = 32'sh80000000;
    localparam coord_t ONE = 32'sh00010000;
    query_t q;
    // degenerate, start, end, interior, extremes, 2D
    pending_q.push_back('{ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0});
    pending_q.push_back('{MX, MX, MX, MX, MX, MX, MN, MN, MN});
    pending_q.push_back('{0, 0, 0, ONE*10, 0, 0, -ONE, 0, 0});
    pending_q.push_back('{0, 0, 0, ONE*10, 0, 0, 0, ONE, 0});
    pending_q.push_back('{0, 0, 0, ONE*10, 0, 0, ONE*10, ONE, 0});
    pending_q.push_back('{0, 0, 0, ONE*10, 0, 0, ONE*20, 0, 0});
    pending_q.push_back('{0, 0, 0, ONE*10, 0, 0, ONE*3, ONE*7, 0});
    pending_q.push_back('{ONE, -ONE, ONE*2, -ONE*3, ONE*4, ONE*5, 0, ONE, ONE});
    pending_q.push_back('{MN, MN, MN, MX, MX, MX, 0, 0, 0});
    pending_q.push_back('{MX, MX, MX, MN, MN, MN, 1, -1, 3});
    pending_q.push_back('{MN, MN, MN, MX, MX, MX, MX, MX, MX});
    pending_q.push_back('{MN, MN, MN, MX, MX, MX, MN, MN, MN});
    pending_q.push_back('{MN, 0, 0, MX, 0, 0, 0, MX, 0});
    pending_q.push_back('{0, 0, 0, 1, 0, 0, 0, 0, 0});
    pending_q.push_back('{0, 0, 0, 3, 0, 0, 1, 0, 0});
    pending_q.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    pending_q.push_back('{-1, -1, -1, 0, 0, 0, MX, MN, 5});
    for (int i = 0; i < N_RANDOM; i++) begin
      q = rnd_query();
      pending_q.push_back(q);
    end
  end

  // Reset and phase control
  initial begin
    rst_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // receiver hold-off while sender keeps offering
    wait (pending_q.size() < N_RANDOM - 100);
    @(posedge clk);
    hold_out <= 1;
    repeat (60) @(posedge clk);
    hold_out <= 0;
    // sender pause until drained
    wait (pending_q.size() < N_RANDOM - 600);
    @(posedge clk);
    pause_in <= 1;
    wait (closest_q.size() == 0);
    @(posedge clk);
    pause_in <= 0;
    wait (pending_q.size() < 200);
    calm <= 1;
    wait (pending_q.size() == 0 && !in_chan.valid);
    wait (closest_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // Driver: bursts of idling on the sending side
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 0;
      {in_chan.a_x, in_chan.a_y, in_chan.a_z} <= '0;
      {in_chan.b_x, in_chan.b_y, in_chan.b_z} <= '0;
      {in_chan.p_x, in_chan.p_y, in_chan.p_z} <= '0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) closest_q.push_back(closest_point(
        '{in_chan.a_x, in_chan.a_y, in_chan.a_z, in_chan.b_x, in_chan.b_y,
          in_chan.b_z, in_chan.p_x, in_chan.p_y, in_chan.p_z}));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_chan.valid <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 5);
        in_chan.valid <= 0;
      end else if (pause_in || pending_q.size() == 0) begin
        in_chan.valid <= 0;
      end else begin
        query_t q;
        q = pending_q.pop_front();
        in_chan.valid <= 1;
        {in_chan.a_x, in_chan.a_y, in_chan.a_z} <= {q.a_x, q.a_y, q.a_z};
        {in_chan.b_x, in_chan.b_y, in_chan.b_z} <= {q.b_x, q.b_y, q.b_z};
        {in_chan.p_x, in_chan.p_y, in_chan.p_z} <= {q.p_x, q.p_y, q.p_z};
      end
    end
  end

  // Monitor: checks each result transaction, stalls in bursts
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (closest_q.size() == 0) begin
          $error("unexpected result transaction");
          n_fail++;
        end else begin
          point_t e;
          e = closest_q.pop_front();
          if (out_chan.q_x !== e.q_x) begin
            $error("q_x expected %0d actual %0d", e.q_x, out_chan.q_x); n_fail++;
          end
          if (out_chan.q_y !== e.q_y) begin
            $error("q_y expected %0d actual %0d", e.q_y, out_chan.q_y); n_fail++;
          end
          if (out_chan.q_z !== e.q_z) begin
            $error("q_z expected %0d actual %0d", e.q_z, out_chan.q_z); n_fail++;
          end
          if (out_chan.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_chan.status);
            n_fail++;
          end
        end
      end
      if (hold_out) begin
        out_chan.ready <= 0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_chan.ready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 5);
        out_chan.ready <= 0;
      end else begin
        out_chan.ready <= 1;
      end
    end
  end

endmodule
